// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The expression must never be true.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== src/dpofifo_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual-port overwriting receive FIFO package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dpofifo_pkg;

    localparam int KBD_DEPTH  = 2 * 16;
    localparam int AUX_DEPTH  = 4 * 32;
    localparam int KBD_PTR_W  = $clog2(KBD_DEPTH);
    localparam int AUX_PTR_W  = $clog2(AUX_DEPTH);
    localparam int OPQ_DEPTH  = 2;
    localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int CFG_IDX_W  = 1;

    localparam logic [7:0] STATUS_NONE = 8'hFF;
    localparam logic [7:0] STATUS_FULL = 8'h01;
    localparam logic [7:0] STATUS_AUX  = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_KBD_PRESENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AUX_PRESENT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PUSH     = 2'd0,
        KIND_POP_KBD  = 2'd1,
        KIND_POP_AUX  = 2'd2,
        KIND_PEEK_KBD = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_KBD,
        OP_PUSH_AUX,
        OP_POP_KBD,
        OP_POP_AUX,
        OP_PEEK_KBD
    } op_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_KBD,
        SRC_AUX
    } src_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ctrl_status;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       kbd_ready;
        logic       aux_ready;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } op_item_t;

    typedef struct packed {
        logic kbd;
        logic aux;
    } present_t;

    function automatic logic [KBD_PTR_W-1:0] kbd_inc(input logic [KBD_PTR_W-1:0] p);
        logic [KBD_PTR_W-1:0] r;
        if (p == KBD_PTR_W'(KBD_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [AUX_PTR_W-1:0] aux_inc(input logic [AUX_PTR_W-1:0] p);
        logic [AUX_PTR_W-1:0] r;
        if (p == AUX_PTR_W'(AUX_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/dual_port_overwriting_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// Dual-port overwriting receive FIFO
// Sorts received controller bytes into a keyboard and an auxiliary ring
// buffer and serves pops on both and peeks on the keyboard buffer.
// ----------------------------------------------------------------------------
// Input transactions are pushed with push while full is low; each carries a
// kind, a status byte and a data byte. Every input transaction yields exactly
// one result transaction, popped with pop while empty is low.
// The block sustains one transaction per cycle while the receiver pops; the
// back end executes one buffer operation per cycle while the result queue
// has room, with a write and a read port per buffer. A two-entry operation
// queue decouples decode from execution, and a four-entry result queue
// absorbs receiver stalls; when the receiver stalls, these queues fill and
// full rises after at most six accepted transactions.
// Port registers are written through cfg_wr_en, cfg_index and cfg_data; a
// write loads that port's present bit from cfg_data and empties its buffer.
// Reset empties both buffers, marks both ports absent and clears the queues.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_port_overwriting_rx_fifo
    import dpofifo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [0:0]           cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire in_item_t             in_data,
    output logic                      empty,
    input  wire logic                 pop,
    output out_item_t                 out_data
);

    present_t  present;
    logic      op_valid;
    op_item_t  op_entry;
    logic      op_take;
    logic      out_room;
    logic      q_full;
    logic      res_valid;
    out_item_t res_item;

    dpofifo_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .present  (present),
        .op_valid (op_valid),
        .op_entry (op_entry),
        .op_take  (op_take)
    );

    dpofifo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (op_valid),
        .op_entry  (op_entry),
        .op_take   (op_take),
        .out_room  (out_room),
        .present   (present),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    dpofifo_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_item  (res_item),
        .out_room  (out_room),
        .q_full    (q_full),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

`include "assert_macros.svh"

    `ASSERT_NEVER(a_outq_no_overflow, res_valid && q_full, "Result dropped into a full queue.")
    `ASSERT_IMPLIES(a_take_needs_op, op_take, op_valid, "Operation taken from an empty queue.")
    `ASSERT_IMPLIES(a_kbd_ready_present, !empty && out_data.kbd_ready, present.kbd,
        "Keyboard ready shown for an absent port.")
    `ASSERT_IMPLIES(a_aux_ready_present, !empty && out_data.aux_ready, present.aux,
        "Auxiliary ready shown for an absent port.")

endmodule

`default_nettype wire

// ===== src/dpofifo_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts input transactions, decodes them into buffer operations and holds
// them in a small operation queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dpofifo_front
    import dpofifo_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_data,
    input  wire present_t present,
    output logic          op_valid,
    output op_item_t      op_entry,
    input  wire logic     op_take
);

    op_item_t               opq_mem [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0]   count_reg, count_next;
    logic                   enq;
    logic                   deq;
    logic                   status_ok;
    op_item_t               dec_item;

    always_comb
    begin
        status_ok = (in_data.ctrl_status != STATUS_NONE)
                    && ((in_data.ctrl_status & STATUS_FULL) != 8'h00);
        dec_item.rx_byte = in_data.rx_byte;
        dec_item.op = OP_NONE;
        case (kind_t'(in_data.kind))
            KIND_PUSH:
            begin
                if (status_ok) begin
                    if ((in_data.ctrl_status & STATUS_AUX) != 8'h00) begin
                        if (present.aux) dec_item.op = OP_PUSH_AUX;
                    end else begin
                        if (present.kbd) dec_item.op = OP_PUSH_KBD;
                    end
                end
            end
            KIND_POP_KBD:
            begin
                if (present.kbd) dec_item.op = OP_POP_KBD;
            end
            KIND_POP_AUX:
            begin
                if (present.aux) dec_item.op = OP_POP_AUX;
            end
            KIND_PEEK_KBD:
            begin
                if (present.kbd) dec_item.op = OP_PEEK_KBD;
            end
            default:
            begin
                dec_item.op = OP_NONE;
            end
        endcase
    end

    assign full     = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op_entry = opq_mem[rd_ptr_reg];
    assign enq      = push && !full;
    assign deq      = op_take && op_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq) begin
            wr_ptr_next = (wr_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq) begin
            rd_ptr_next = (rd_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq) begin
            count_next = count_reg + 1'b1;
        end else if (deq && !enq) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq) begin
            opq_mem[wr_ptr_reg] <= dec_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/dpofifo_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Holds the keyboard and auxiliary ring buffers and the port registers; it
// runs one buffer operation per cycle in two stages while out_room is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dpofifo_back
    import dpofifo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [0:0]           cfg_data,
    input  wire logic                 op_valid,
    input  wire op_item_t             op_entry,
    output logic                      op_take,
    input  wire logic                 out_room,
    output present_t                  present,
    output logic                      res_valid,
    output out_item_t                 res_item
);

    logic [7:0]           kbd_mem [KBD_DEPTH];
    logic [7:0]           aux_mem [AUX_DEPTH];
    logic [7:0]           kbd_rdata_reg;
    logic [7:0]           aux_rdata_reg;
    present_t             present_reg;
    logic [KBD_PTR_W-1:0] kbd_wr_reg, kbd_wr_next;
    logic [KBD_PTR_W-1:0] kbd_rd_reg, kbd_rd_next;
    logic [AUX_PTR_W-1:0] aux_wr_reg, aux_wr_next;
    logic [AUX_PTR_W-1:0] aux_rd_reg, aux_rd_next;
    logic                 kbd_we;
    logic                 aux_we;
    logic                 kbd_empty;
    logic                 aux_empty;
    src_t                 src_next;
    logic                 b_valid_reg;
    src_t                 b_src_reg;
    logic                 b_kbd_rdy_reg;
    logic                 b_aux_rdy_reg;

    assign present   = present_reg;
    assign op_take   = op_valid && out_room;
    assign kbd_empty = (kbd_wr_reg == kbd_rd_reg);
    assign aux_empty = (aux_wr_reg == aux_rd_reg);

    always_comb
    begin
        kbd_wr_next = kbd_wr_reg;
        kbd_rd_next = kbd_rd_reg;
        aux_wr_next = aux_wr_reg;
        aux_rd_next = aux_rd_reg;
        kbd_we      = 1'b0;
        aux_we      = 1'b0;
        src_next    = SRC_ZERO;
        if (op_take) begin
            case (op_entry.op)
                OP_PUSH_KBD:
                begin
                    kbd_we      = 1'b1;
                    kbd_wr_next = kbd_inc(kbd_wr_reg);
                    if (kbd_wr_next == kbd_rd_reg) begin
                        kbd_rd_next = kbd_inc(kbd_rd_reg);
                    end
                end
                OP_PUSH_AUX:
                begin
                    aux_we      = 1'b1;
                    aux_wr_next = aux_inc(aux_wr_reg);
                    if (aux_wr_next == aux_rd_reg) begin
                        aux_rd_next = aux_inc(aux_rd_reg);
                    end
                end
                OP_POP_KBD:
                begin
                    if (!kbd_empty) begin
                        src_next    = SRC_KBD;
                        kbd_rd_next = kbd_inc(kbd_rd_reg);
                    end
                end
                OP_POP_AUX:
                begin
                    if (!aux_empty) begin
                        src_next    = SRC_AUX;
                        aux_rd_next = aux_inc(aux_rd_reg);
                    end
                end
                OP_PEEK_KBD:
                begin
                    if (!kbd_empty) begin
                        src_next = SRC_KBD;
                    end
                end
                default:
                begin
                    src_next = SRC_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            present_reg   <= '0;
            kbd_wr_reg    <= '0;
            kbd_rd_reg    <= '0;
            aux_wr_reg    <= '0;
            aux_rd_reg    <= '0;
            b_valid_reg   <= 1'b0;
            b_src_reg     <= SRC_ZERO;
            b_kbd_rdy_reg <= 1'b0;
            b_aux_rdy_reg <= 1'b0;
        end else begin
            b_valid_reg <= op_take;
            if (op_take) begin
                b_src_reg     <= src_next;
                b_kbd_rdy_reg <= present_reg.kbd && (kbd_wr_next != kbd_rd_next);
                b_aux_rdy_reg <= present_reg.aux && (aux_wr_next != aux_rd_next);
            end
            if (cfg_wr_en && (cfg_index == REG_KBD_PRESENT)) begin
                present_reg.kbd <= cfg_data[0];
                kbd_wr_reg      <= '0;
                kbd_rd_reg      <= '0;
            end else begin
                kbd_wr_reg <= kbd_wr_next;
                kbd_rd_reg <= kbd_rd_next;
            end
            if (cfg_wr_en && (cfg_index == REG_AUX_PRESENT)) begin
                present_reg.aux <= cfg_data[0];
                aux_wr_reg      <= '0;
                aux_rd_reg      <= '0;
            end else begin
                aux_wr_reg <= aux_wr_next;
                aux_rd_reg <= aux_rd_next;
            end
        end
    end

    // The head entry is read every cycle; a write never lands on the head of
    // a non-empty buffer, so the registered data is always current.
    always_ff @(posedge clk)
    begin
        if (kbd_we) begin
            kbd_mem[kbd_wr_reg] <= op_entry.rx_byte;
        end
        kbd_rdata_reg <= kbd_mem[kbd_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (aux_we) begin
            aux_mem[aux_wr_reg] <= op_entry.rx_byte;
        end
        aux_rdata_reg <= aux_mem[aux_rd_reg];
    end

    always_comb
    begin
        res_item.kbd_ready = b_kbd_rdy_reg;
        res_item.aux_ready = b_aux_rdy_reg;
        case (b_src_reg)
            SRC_KBD: res_item.read_byte = kbd_rdata_reg;
            SRC_AUX: res_item.read_byte = aux_rdata_reg;
            default: res_item.read_byte = 8'h00;
        endcase
    end

    assign res_valid = b_valid_reg;

endmodule

`default_nettype wire

// ===== src/dpofifo_outq.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Holds finished results until the receiver pops them, and grants the back
// end room for one more operation when at least two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module dpofifo_outq
    import dpofifo_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_valid,
    input  wire out_item_t res_item,
    output logic           out_room,
    output logic           q_full,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      out_data
);

    out_item_t               q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0]   count_reg, count_next;
    logic                    enq;
    logic                    deq;

    assign empty    = (count_reg == '0);
    assign q_full   = (count_reg == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign out_room = (count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign out_data = q_mem[rd_ptr_reg];
    assign enq      = res_valid && !q_full;
    assign deq      = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq) begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq) begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq) begin
            count_next = count_reg + 1'b1;
        end else if (deq && !enq) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq) begin
            q_mem[wr_ptr_reg] <= res_item;
        end
    end

endmodule

`default_nettype wire
